>>> design/assert_macros.svh
// Assertion macros for the design files, included by the top level of the normalizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked assertion, disabled while reset is asserted.
`define ZSN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked assertion that also holds during reset.
`define ZSN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> design/zsn_pkg.sv
// Package with the state type and fixed constants of the z-score normalizer.
package zsn_pkg;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int ROOT_IN_W = 64;
    localparam int ROOT_W    = 32;
    localparam int POS_W     = 6;
    localparam int Z_W       = 16;
    localparam int Z_SHIFT   = 17;
    localparam int VAR_SHIFT = 8;
    localparam int Z_MAX_POS = 32767;
    localparam int Z_MAX_NEG = 32768;

    typedef enum logic [3:0] {
        S_LOAD, S_Q_RD, S_Q_MUL, S_Q_DEV, S_Q_ACC, S_V_START, S_V_WAIT,
        S_R_START, S_R_WAIT, S_E_RD, S_E_MUL, S_E_DEV, S_E_DIV, S_E_WAIT, S_E_OUT
    } t_state;
endpackage

>>> design/zsn_if.sv
// Stream interfaces for the sample input and the z-score output.
interface zsn_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    last_sample;
    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface zsn_out_if;
    logic                        valid;
    logic                        ready;
    logic [zsn_pkg::POS_W-1:0]   position;
    logic signed [zsn_pkg::Z_W-1:0] z_value;
    logic                        flat_data;
    logic                        overflowed;
    logic                        end_of_set;
    modport source (output valid, output position, output z_value, output flat_data,
                    output overflowed, output end_of_set, input ready);
    modport sink (input valid, input position, input z_value, input flat_data,
                  input overflowed, input end_of_set, output ready);
endinterface

>>> design/zsn_store.sv
// Sample memory with one write port and one registered read port.
module zsn_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port: the data follows the address in the next cycle.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/zsn_div.sv
// Restoring divider that produces one quotient bit per cycle.
module zsn_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [zsn_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [zsn_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                            o_done,
    output logic [zsn_pkg::DIV_NUM_W-1:0]   o_quot
);
    localparam int NW = zsn_pkg::DIV_NUM_W;
    localparam int DW = zsn_pkg::DIV_DEN_W;
    localparam int CNTW = $clog2(NW);

    logic [NW-1:0]   r_num, n_num;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [DW:0]     trial;
    logic [DW:0]     diff;

    // One shift and subtract step.
    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        diff  = trial - {1'b0, r_den};
        n_num = {r_num[NW-2:0], 1'b0};
        n_rem = trial[DW-1:0];
        if (trial >= {1'b0, r_den}) begin
            n_num[0] = 1'b1;
            n_rem    = diff[DW-1:0];
        end
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

>>> design/zsn_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
module zsn_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [zsn_pkg::ROOT_IN_W-1:0]   i_val,
    output logic                            o_done,
    output logic [zsn_pkg::ROOT_W-1:0]      o_root
);
    localparam int VW = zsn_pkg::ROOT_IN_W;
    localparam int STEPS = VW / 2;
    localparam int CNTW = $clog2(STEPS);

    logic [VW-1:0]   r_v, r_res, r_bit;
    logic [VW-1:0]   trial;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy, r_done;

    assign trial = r_res + r_bit;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One compare and subtract step per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= VW'(1) << (VW - 2);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[zsn_pkg::ROOT_W-1:0];
endmodule

>>> design/zscore_normalizer.sv
// Top level of the z-score normalizer: sequencer and datapath around the sample memory.
// Usage: samples arrive as words on i_in (valid/ready, accepted when both are high).
// Each word is stored and summed as it is accepted; a word with last_sample set closes
// the set. Words beyond MAX_SAMPLES are dropped and reported as overflowed.
// While the set is being computed and emitted, i_in.ready is low.
// Compute: a variance pass reads each sample from the memory in states S_Q_RD,
// S_Q_MUL, S_Q_DEV, S_Q_ACC and S_R_START, then one 64-step division by the count
// and a 32-step square root follow. Each result then takes a memory read and
// deviation (S_E_RD, S_E_MUL, S_E_DEV), plus a 64-step division (skipped on flat
// data), plus a wait on o_out until the word is taken.
// Results leave o_out in sample order, the final one with end_of_set set.
// When the receiver stalls, the result word is held until o_out.ready is high.
// absolute_mode is written through i_cfg_we/i_cfg_wdata and resets to 1.
// Reset empties the set (count, sum, overflow flag); the memory is not cleared
// and needs no clearing pass.
module zscore_normalizer #(
    parameter int MAX_SAMPLES  = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    zsn_in_if.sink     i_in,
    zsn_out_if.source  o_out
);
    `include "assert_macros.svh"

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int NXW  = SW + CW;
    localparam int DEV  = (SW > 16) ? SW - 16 : 0;
    localparam int MW   = NXW - DEV;
    localparam int QW   = 2 * MW + CW;
    localparam int NUMW = zsn_pkg::DIV_NUM_W;
    localparam int DENW = zsn_pkg::DIV_DEN_W;
    localparam int RW   = zsn_pkg::ROOT_W;
    localparam int ZW   = zsn_pkg::Z_W;

    zsn_pkg::t_state r_state, n_state;

    logic [CW-1:0]   r_count, n_count;
    logic [NXW-1:0]  r_sum, n_sum;
    logic            r_ovf, n_ovf;
    logic            r_mode;
    logic [AW-1:0]   r_idx, n_idx;
    logic [NXW-1:0]  r_nx, n_nx;
    logic [MW-1:0]   r_m, n_m;
    logic            r_neg, n_neg;
    logic [QW-1:0]   r_q, n_q;
    logic [RW-1:0]   r_root, n_root;
    logic            r_flat, n_flat;
    logic [ZW-1:0]   r_z, n_z;
    logic            r_eos, n_eos;

    logic            w_in_ready, w_out_valid;
    logic            w_we;
    logic [SW-1:0]   w_rdata;
    logic            w_div_start, w_div_done;
    logic [NUMW-1:0] w_div_num, w_div_quot;
    logic [DENW-1:0] w_div_den;
    logic            w_sqrt_start, w_sqrt_done;
    logic [RW-1:0]   w_root;
    logic            w_is_last;
    logic [NXW-1:0]  w_dev;
    logic [2*MW-1:0] w_sq;
    logic [16:0]     w_mag;
    logic            w_div_wait;
    logic            w_out_last;

    // Sample memory.
    zsn_store #(.DEPTH(MAX_SAMPLES), .WIDTH(SW), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.sample),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Shared serial divider for the variance and for each z-score on data that is not flat.
    zsn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Square root of the scaled variance.
    zsn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_val   (w_div_quot),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign w_is_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign w_dev     = r_neg ? (r_sum - r_nx) : (r_nx - r_sum);
    assign w_sq      = r_m * r_m;
    assign w_mag     = (w_div_quot > NUMW'(zsn_pkg::Z_MAX_NEG))
                       ? 17'(zsn_pkg::Z_MAX_NEG) : w_div_quot[16:0];

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_sum        = r_sum;
        n_ovf        = r_ovf;
        n_idx        = r_idx;
        n_nx         = r_nx;
        n_m          = r_m;
        n_neg        = r_neg;
        n_q          = r_q;
        n_root       = r_root;
        n_flat       = r_flat;
        n_z          = r_z;
        n_eos        = r_eos;
        w_in_ready   = 1'b0;
        w_out_valid  = 1'b0;
        w_we         = 1'b0;
        w_div_start  = 1'b0;
        w_div_num    = NUMW'(r_q) << zsn_pkg::VAR_SHIFT;
        w_div_den    = DENW'(r_count);
        w_sqrt_start = 1'b0;
        unique case (r_state)
            zsn_pkg::S_LOAD: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    if (r_count < CW'(MAX_SAMPLES)) begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        n_sum   = r_sum + NXW'(i_in.sample);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_sample) begin
                        n_idx   = '0;
                        n_q     = '0;
                        n_state = zsn_pkg::S_Q_RD;
                    end
                end
            end
            zsn_pkg::S_Q_RD: n_state = zsn_pkg::S_Q_MUL;
            zsn_pkg::S_Q_MUL: begin
                n_nx    = NXW'(r_count) * NXW'(w_rdata);
                n_state = zsn_pkg::S_Q_DEV;
            end
            zsn_pkg::S_Q_DEV: begin
                n_neg   = r_nx < r_sum;
                n_state = zsn_pkg::S_Q_ACC;
            end
            zsn_pkg::S_Q_ACC: begin
                // The deviation is formed here and squared in the next state.
                n_m     = MW'(w_dev >> DEV);
                n_state = zsn_pkg::S_R_START;
            end
            zsn_pkg::S_R_START: begin
                // Accumulate the square of this sample's deviation.
                n_q = r_q + QW'(w_sq);
                if (w_is_last) begin
                    n_state = zsn_pkg::S_V_START;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = zsn_pkg::S_Q_RD;
                end
            end
            zsn_pkg::S_V_START: begin
                w_div_start = 1'b1;
                n_state     = zsn_pkg::S_V_WAIT;
            end
            zsn_pkg::S_V_WAIT: begin
                if (w_div_done) begin
                    w_sqrt_start = 1'b1;
                    n_state      = zsn_pkg::S_R_WAIT;
                end
            end
            zsn_pkg::S_R_WAIT: begin
                if (w_sqrt_done) begin
                    n_root  = w_root;
                    n_flat  = (r_q == '0) || (w_root == '0);
                    n_idx   = '0;
                    n_state = zsn_pkg::S_E_RD;
                end
            end
            zsn_pkg::S_E_RD: n_state = zsn_pkg::S_E_MUL;
            zsn_pkg::S_E_MUL: begin
                n_nx    = NXW'(r_count) * NXW'(w_rdata);
                n_state = zsn_pkg::S_E_DEV;
            end
            zsn_pkg::S_E_DEV: begin
                n_neg   = r_nx < r_sum;
                n_state = zsn_pkg::S_E_DIV;
            end
            zsn_pkg::S_E_DIV: begin
                n_m   = MW'(w_dev >> DEV);
                n_eos = w_is_last;
                if (r_flat) begin
                    n_z     = '0;
                    n_state = zsn_pkg::S_E_OUT;
                end else begin
                    w_div_start = 1'b1;
                    w_div_num   = (NUMW'(MW'(w_dev >> DEV)) << zsn_pkg::Z_SHIFT)
                                  + NUMW'(r_root);
                    w_div_den   = DENW'(r_root) << 1;
                    n_state     = zsn_pkg::S_E_WAIT;
                end
            end
            zsn_pkg::S_E_WAIT: begin
                if (w_div_done) begin
                    if (r_mode || !r_neg) begin
                        n_z = (w_mag > 17'(zsn_pkg::Z_MAX_POS))
                              ? ZW'(zsn_pkg::Z_MAX_POS) : w_mag[ZW-1:0];
                    end else begin
                        n_z = ZW'(17'd0 - w_mag);
                    end
                    n_state = zsn_pkg::S_E_OUT;
                end
            end
            zsn_pkg::S_E_OUT: begin
                w_out_valid = 1'b1;
                if (o_out.ready) begin
                    if (r_eos) begin
                        n_count = '0;
                        n_sum   = '0;
                        n_ovf   = 1'b0;
                        n_state = zsn_pkg::S_LOAD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = zsn_pkg::S_E_RD;
                    end
                end
            end
            default: n_state = zsn_pkg::S_LOAD;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zsn_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_mode  <= 1'b1;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_nx   <= n_nx;
        r_m    <= n_m;
        r_neg  <= n_neg;
        r_q    <= n_q;
        r_root <= n_root;
        r_flat <= n_flat;
        r_z    <= n_z;
        r_eos  <= n_eos;
    end

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = w_out_valid;
    assign o_out.position   = zsn_pkg::POS_W'(r_idx);
    assign o_out.z_value    = r_z;
    assign o_out.flat_data  = r_flat;
    assign o_out.overflowed = r_ovf;
    assign o_out.end_of_set = r_eos;

    // Terms used by the checks below.
    assign w_div_wait = (r_state == zsn_pkg::S_V_WAIT) || (r_state == zsn_pkg::S_E_WAIT);
    assign w_out_last = w_out_valid && o_out.ready && r_eos;

    // Checks on the sequencer.
    `ZSN_ASSERT_ALWAYS(a_no_overlap, i_clk, !(w_in_ready && w_out_valid), "ready with result")
    `ZSN_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_SAMPLES), "count past depth")
    `ZSN_ASSERT(a_div_wait, i_clk, i_rst_n, w_div_done |-> w_div_wait, "stray divide")
    `ZSN_ASSERT(a_set_clear, i_clk, i_rst_n, w_out_last |=> (r_count == '0), "set not cleared")
endmodule
